[hw/rtl/circle_box_collision_top_macros.svh]
// Assertion macros for the circle/box collision block.
`ifndef CIRCLE_BOX_COLLISION_TOP_MACROS_SVH
`define CIRCLE_BOX_COLLISION_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Implication property checked on every rising edge outside reset.
`define CBC_ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: property failed");
// Condition that must never be true outside reset.
`define CBC_ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define CBC_ASSERT_PROP(lbl, clk, rst, prop)
`define CBC_ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

[hw/rtl/cbc_pkg.sv]
// Shared types and constants for the circle/box collision block.
`default_nettype none

package cbc_pkg;

  // Default coordinate field width (unsigned Q12.4)
  localparam int COORD_BITS_DEF = 16;

  // Direction of the offset from ball centre to closest box point
  typedef enum logic [1:0] {
    SIDE_UP    = 2'd0,
    SIDE_RIGHT = 2'd1,
    SIDE_DOWN  = 2'd2,
    SIDE_LEFT  = 2'd3
  } side_t;

endpackage

`default_nettype wire

[hw/rtl/cbc_side.sv]
// Direction pick and result zeroing for the final pipeline stage.
`default_nettype none

module cbc_side #(
  parameter int OFF_W = cbc_pkg::COORD_BITS_DEF + 2
) (
  input  wire logic                    hit,
  input  wire logic signed [OFF_W-1:0] ox,
  input  wire logic signed [OFF_W-1:0] oy,
  output cbc_pkg::side_t               side,
  output logic signed [OFF_W-1:0]      offset_x,
  output logic signed [OFF_W-1:0]      offset_y
);
  import cbc_pkg::*;

  logic signed [OFF_W:0] ex;
  logic signed [OFF_W:0] ey;
  logic signed [OFF_W:0] best;
  side_t                 pick;

  assign ex = {ox[OFF_W-1], ox};
  assign ey = {oy[OFF_W-1], oy};

  // First strict maximum among positive values of oy, ox, -oy, -ox
  always_comb begin
    best = '0;
    pick = SIDE_UP;
    if (ey > best) begin
      best = ey;
      pick = SIDE_UP;
    end
    if (ex > best) begin
      best = ex;
      pick = SIDE_RIGHT;
    end
    if (-ey > best) begin
      best = -ey;
      pick = SIDE_DOWN;
    end
    if (-ex > best) begin
      best = -ex;
      pick = SIDE_LEFT;
    end
  end

  // A miss reports up with a zero offset
  always_comb begin
    if (hit) begin
      side     = pick;
      offset_x = ox;
      offset_y = oy;
    end else begin
      side     = SIDE_UP;
      offset_x = '0;
      offset_y = '0;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/circle_box_collision_top.sv]
// Top level of the circle versus axis-aligned box collision test.
// Usage:
//   Input channel (in_valid/in_ready) carries one ball/box pair per request:
//   ball corner, radius, box corner and size, all unsigned Q12.4.
//   Output channel (out_valid/out_ready) returns hit, side and the signed
//   Q13.5 offset from the ball centre to the closest box point.
//   Each request passes through five register stages, the first loaded at
//   the edge that accepts it: centre difference, clamp, magnitude and range
//   check, squares, then sum compare with direction pick into the output
//   register, whose valid bit drives out_valid.
//   Throughput: one request per cycle while out_ready is high; the squaring
//   stage with its three multipliers sets the clock period.
//   Stalls: when out_ready is low the result holds; bubbles inside the
//   pipeline are still filled, so in_ready drops only once all five stages
//   hold a request. Nothing is lost or repeated.
//   Reset: rst (synchronous) empties every stage; in_ready is high the
//   cycle after reset is released.
`default_nettype none
`include "circle_box_collision_top_macros.svh"

module circle_box_collision_top #(
  parameter int COORD_BITS = cbc_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [COORD_BITS-1:0]        ball_x,
  input  wire logic [COORD_BITS-1:0]        ball_y,
  input  wire logic [COORD_BITS-1:0]        ball_radius,
  input  wire logic [COORD_BITS-1:0]        box_x,
  input  wire logic [COORD_BITS-1:0]        box_y,
  input  wire logic [COORD_BITS-1:0]        box_w,
  input  wire logic [COORD_BITS-1:0]        box_h,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              hit,
  output logic [1:0]                        side,
  output logic signed [COORD_BITS+1:0]      offset_x,
  output logic signed [COORD_BITS+1:0]      offset_y
);
  import cbc_pkg::*;

  localparam int DW    = COORD_BITS + 4;      // doubled-unit differences
  localparam int OFF_W = COORD_BITS + 2;      // offsets on a hit
  localparam int MW    = COORD_BITS + 1;      // magnitudes within range
  localparam int SQ_W  = 2 * MW;              // squares

  // Stage valid bits and advance enables
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  assign en5      = !v5 || out_ready;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // Stage 1: centre difference in doubled units
  logic [DW-1:0]        ball_cx2, ball_cy2, box_cx2, box_cy2;
  logic signed [DW-1:0] s1_dx, s1_dy;
  logic [COORD_BITS-1:0] s1_w, s1_h, s1_r;

  assign ball_cx2 = ({4'b0, ball_x} + {4'b0, ball_radius}) << 1;
  assign ball_cy2 = ({4'b0, ball_y} + {4'b0, ball_radius}) << 1;
  assign box_cx2  = ({4'b0, box_x} << 1) + {4'b0, box_w};
  assign box_cy2  = ({4'b0, box_y} << 1) + {4'b0, box_h};

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_dx <= signed'(ball_cx2 - box_cx2);
      s1_dy <= signed'(ball_cy2 - box_cy2);
      s1_w  <= box_w;
      s1_h  <= box_h;
      s1_r  <= ball_radius;
    end
  end

  // Stage 2: clamp to the half extents, offset = clamped - difference
  logic signed [DW-1:0] lim_x, lim_y, ox_c, oy_c;
  logic signed [DW-1:0] s2_ox, s2_oy;
  logic [COORD_BITS-1:0] s2_r;

  assign lim_x = signed'({4'b0, s1_w});
  assign lim_y = signed'({4'b0, s1_h});

  always_comb begin
    if (s1_dx > lim_x) begin
      ox_c = lim_x - s1_dx;
    end else if (s1_dx < -lim_x) begin
      ox_c = -lim_x - s1_dx;
    end else begin
      ox_c = '0;
    end
    if (s1_dy > lim_y) begin
      oy_c = lim_y - s1_dy;
    end else if (s1_dy < -lim_y) begin
      oy_c = -lim_y - s1_dy;
    end else begin
      oy_c = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_ox <= ox_c;
      s2_oy <= oy_c;
      s2_r  <= s1_r;
    end
  end

  // Stage 3: magnitudes and the per-axis range check against 2r
  logic [DW-1:0]         mag_x, mag_y;
  logic [DW-1:0]         r2_w;
  logic                  in_rng;
  logic [MW-1:0]         s3_mx, s3_my, s3_r2;
  logic                  s3_inr;
  logic signed [OFF_W-1:0] s3_ox, s3_oy;

  assign mag_x  = s2_ox[DW-1] ? DW'(-s2_ox) : DW'(s2_ox);
  assign mag_y  = s2_oy[DW-1] ? DW'(-s2_oy) : DW'(s2_oy);
  assign r2_w   = {3'b0, s2_r, 1'b0};
  assign in_rng = (mag_x <= r2_w) && (mag_y <= r2_w);

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_mx  <= mag_x[MW-1:0];
      s3_my  <= mag_y[MW-1:0];
      s3_r2  <= {s2_r, 1'b0};
      s3_inr <= in_rng;
      s3_ox  <= s2_ox[OFF_W-1:0];
      s3_oy  <= s2_oy[OFF_W-1:0];
    end
  end

  // Stage 4: squares
  logic [SQ_W-1:0]         sq_x, sq_y, sq_r;
  logic [SQ_W-1:0]         s4_sx, s4_sy, s4_sr;
  logic                    s4_inr;
  logic signed [OFF_W-1:0] s4_ox, s4_oy;

  assign sq_x = SQ_W'(s3_mx) * SQ_W'(s3_mx);
  assign sq_y = SQ_W'(s3_my) * SQ_W'(s3_my);
  assign sq_r = SQ_W'(s3_r2) * SQ_W'(s3_r2);

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_sx  <= sq_x;
      s4_sy  <= sq_y;
      s4_sr  <= sq_r;
      s4_inr <= s3_inr;
      s4_ox  <= s3_ox;
      s4_oy  <= s3_oy;
    end
  end

  // Stage 5: distance compare, direction pick, output register
  logic [SQ_W:0]           dist2;
  logic                    hit_c;
  side_t                   side_c;
  logic signed [OFF_W-1:0] offx_c, offy_c;
  side_t                   s5_side;

  assign dist2 = {1'b0, s4_sx} + {1'b0, s4_sy};
  assign hit_c = s4_inr && (dist2 <= {1'b0, s4_sr});

  cbc_side #(
    .OFF_W (OFF_W)
  ) u_side (
    .hit      (hit_c),
    .ox       (s4_ox),
    .oy       (s4_oy),
    .side     (side_c),
    .offset_x (offx_c),
    .offset_y (offy_c)
  );

  always_ff @(posedge clk) begin
    if (en5) begin
      hit      <= hit_c;
      s5_side  <= side_c;
      offset_x <= offx_c;
      offset_y <= offy_c;
    end
  end

  assign side      = s5_side;
  assign out_valid = v5;

  // Checks
  `CBC_ASSERT_PROP(a_miss_zero, clk, rst,
    (out_valid && !hit) |-> (offset_x == '0 && offset_y == '0 && s5_side == SIDE_UP))
  `CBC_ASSERT_NEVER(a_ready_low_only_full, clk, rst,
    !in_ready && !(v1 && v2 && v3 && v4 && v5 && !out_ready))
  `CBC_ASSERT_PROP(a_stall_holds_s1, clk, rst,
    (v1 && !en2) |=> (v1 && $stable(s1_dx) && $stable(s1_dy)))

endmodule

`default_nettype wire
